// ----- rtl/ppmp6_pkg.sv -----
// PPM P6 stream parser: shared types, codes and constants.
// Used by ppmp6_parse and ppm_p6_stream_parser_unit; depends on nothing.
package ppmp6_pkg;

    // Default parameter values
    localparam int MAX_TOKEN_LEN_DEF = 15;
    localparam int DIM_BITS_DEF      = 16;

    // Fixed field widths
    localparam int BYTE_W   = 8;
    localparam int SAMPLE_W = 16;
    localparam int IMG_W    = 16;
    localparam int ACC_W    = 17;

    // Number accumulator saturates here (one above the largest legal value)
    localparam logic [ACC_W-1:0] ACC_SAT = 17'd65536;

    // Characters
    localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
    localparam logic [BYTE_W-1:0] CH_6     = 8'h36;
    localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
    localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_VT    = 8'h0b;
    localparam logic [BYTE_W-1:0] CH_FF    = 8'h0c;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;

    // Result kinds
    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_MAGIC = 3'd1;
    localparam logic [2:0] ERR_BAD_NUM   = 3'd2;
    localparam logic [2:0] ERR_TOO_LONG  = 3'd3;
    localparam logic [2:0] ERR_TRUNC     = 3'd4;

    // Token positions in the header
    localparam logic [1:0] TOK_MAGIC  = 2'd0;
    localparam logic [1:0] TOK_WIDTH  = 2'd1;
    localparam logic [1:0] TOK_HEIGHT = 2'd2;
    localparam logic [1:0] TOK_MAXVAL = 2'd3;

    // Color component indexes
    localparam logic [1:0] COMP_RED  = 2'd0;
    localparam logic [1:0] COMP_BLUE = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_DATA,
        PH_SKIP
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          result_kind;
        logic [SAMPLE_W-1:0] sample_value;
        logic [1:0]          component;
        logic                last_sample;
        logic [IMG_W-1:0]    image_width;
        logic [IMG_W-1:0]    image_height;
        logic [2:0]          error_code;
    } t_out_item;

    // One parser step: whether a result is produced, and the result
    typedef struct packed {
        logic      has_result;
        t_out_item item;
    } t_step;

    function automatic logic is_delim(input logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
               (c == CH_FF) || (c == CH_CR) || (c == CH_HASH);
    endfunction

endpackage

// ----- rtl/ppmp6_parse.sv -----
// PPM P6 stream parser: header tokenizer and pixel sample unpacker.
// Holds all parse state and updates it once per accepted byte; depends on ppmp6_pkg.
module ppmp6_parse #(
    parameter int MAX_TOKEN_LEN = ppmp6_pkg::MAX_TOKEN_LEN_DEF,
    parameter int DIM_BITS      = ppmp6_pkg::DIM_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  ppmp6_pkg::t_in_item i_item,
    output ppmp6_pkg::t_step    o_step
);

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam int ACC_W = ppmp6_pkg::ACC_W;

    ppmp6_pkg::t_phase r_phase, n_phase;
    logic [1:0]          r_tok_num, n_tok_num;
    logic [LEN_W-1:0]    r_tok_len, n_tok_len;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic                r_dig_end, n_dig_end;
    logic                r_magic, n_magic;
    logic                r_in_cmt, n_in_cmt;
    logic [DIM_BITS-1:0] r_width, n_width;
    logic [DIM_BITS-1:0] r_height, n_height;
    logic                r_two_byte, n_two_byte;
    logic [7:0]          r_hi_hold, n_hi_hold;
    logic                r_byte_ph, n_byte_ph;
    logic [1:0]          r_comp, n_comp;
    logic [DIM_BITS-1:0] r_col, n_col;
    logic [DIM_BITS-1:0] r_row, n_row;

    logic [7:0]          c;
    logic                digit;
    logic [ACC_W+3:0]    acc_next;
    logic                do_rearm;
    ppmp6_pkg::t_phase rearm_phase;
    logic                last;

    assign c     = i_item.data_byte;
    assign digit = (c >= ppmp6_pkg::CH_0) && (c <= ppmp6_pkg::CH_9);
    // acc*10 + digit, built from shifts
    assign acc_next = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} +
                      {{(ACC_W-4){1'b0}}, c - ppmp6_pkg::CH_0};
    assign last = (r_comp == ppmp6_pkg::COMP_BLUE) &&
                  (r_col == r_width - DIM_BITS'(1)) && (r_row == r_height - DIM_BITS'(1));

    always_comb begin
        n_phase     = r_phase;
        n_tok_num   = r_tok_num;
        n_tok_len   = r_tok_len;
        n_acc       = r_acc;
        n_dig_end   = r_dig_end;
        n_magic     = r_magic;
        n_in_cmt    = r_in_cmt;
        n_width     = r_width;
        n_height    = r_height;
        n_two_byte  = r_two_byte;
        n_hi_hold   = r_hi_hold;
        n_byte_ph   = r_byte_ph;
        n_comp      = r_comp;
        n_col       = r_col;
        n_row       = r_row;
        do_rearm    = 1'b0;
        rearm_phase = ppmp6_pkg::PH_HEADER;
        o_step      = '0;

        if (i_fire) begin
            case (r_phase)
                ppmp6_pkg::PH_HEADER: begin
                    if (i_item.end_of_input) begin
                        o_step.has_result       = 1'b1;
                        o_step.item.result_kind = ppmp6_pkg::KIND_ERROR;
                        o_step.item.error_code  = ppmp6_pkg::ERR_TRUNC;
                        do_rearm                = 1'b1;
                    end else if (r_in_cmt) begin
                        if (c == ppmp6_pkg::CH_LF) begin
                            n_in_cmt = 1'b0;
                        end
                    end else if (ppmp6_pkg::is_delim(c)) begin
                        if (r_tok_len != '0) begin
                            // token ends: check and store it
                            if (r_tok_num == ppmp6_pkg::TOK_MAGIC &&
                                    (!r_magic || r_tok_len != LEN_W'(2))) begin
                                o_step.has_result       = 1'b1;
                                o_step.item.result_kind = ppmp6_pkg::KIND_ERROR;
                                o_step.item.error_code  = ppmp6_pkg::ERR_BAD_MAGIC;
                                do_rearm                = 1'b1;
                                rearm_phase             = ppmp6_pkg::PH_SKIP;
                            end else if (r_tok_num != ppmp6_pkg::TOK_MAGIC && (!r_magic ||
                                    (r_tok_num != ppmp6_pkg::TOK_MAXVAL &&
                                     (|r_acc[ACC_W-1:DIM_BITS])) ||
                                    r_acc[ACC_W-1])) begin
                                o_step.has_result       = 1'b1;
                                o_step.item.result_kind = ppmp6_pkg::KIND_ERROR;
                                o_step.item.error_code  = ppmp6_pkg::ERR_BAD_NUM;
                                do_rearm                = 1'b1;
                                rearm_phase             = ppmp6_pkg::PH_SKIP;
                            end else if (r_tok_num == ppmp6_pkg::TOK_MAXVAL) begin
                                n_two_byte               = |r_acc[ACC_W-2:8];
                                o_step.has_result        = 1'b1;
                                o_step.item.result_kind  = ppmp6_pkg::KIND_HEADER;
                                o_step.item.image_width  = ppmp6_pkg::IMG_W'(r_width);
                                o_step.item.image_height = ppmp6_pkg::IMG_W'(r_height);
                                do_rearm                 = 1'b1;
                                rearm_phase = (r_width == '0 || r_height == '0) ?
                                              ppmp6_pkg::PH_SKIP : ppmp6_pkg::PH_DATA;
                            end else begin
                                if (r_tok_num == ppmp6_pkg::TOK_WIDTH) begin
                                    n_width = r_acc[DIM_BITS-1:0];
                                end
                                if (r_tok_num == ppmp6_pkg::TOK_HEIGHT) begin
                                    n_height = r_acc[DIM_BITS-1:0];
                                end
                                n_tok_num = r_tok_num + 2'd1;
                                n_tok_len = '0;
                                n_acc     = '0;
                                n_dig_end = 1'b0;
                                n_magic   = 1'b1;
                                n_in_cmt  = (c == ppmp6_pkg::CH_HASH);
                            end
                        end else if (c == ppmp6_pkg::CH_HASH) begin
                            n_in_cmt = 1'b1;
                        end
                    end else if (r_tok_len == LEN_W'(MAX_TOKEN_LEN)) begin
                        o_step.has_result       = 1'b1;
                        o_step.item.result_kind = ppmp6_pkg::KIND_ERROR;
                        o_step.item.error_code  = ppmp6_pkg::ERR_TOO_LONG;
                        do_rearm                = 1'b1;
                        rearm_phase             = ppmp6_pkg::PH_SKIP;
                    end else begin
                        if (r_tok_num == ppmp6_pkg::TOK_MAGIC) begin
                            if ((r_tok_len == LEN_W'(0) && c != ppmp6_pkg::CH_P) ||
                                (r_tok_len == LEN_W'(1) && c != ppmp6_pkg::CH_6) ||
                                (r_tok_len >= LEN_W'(2))) begin
                                n_magic = 1'b0;
                            end
                        end else if (r_tok_len == '0 && !digit) begin
                            n_magic   = 1'b0;
                            n_dig_end = 1'b1;
                        end else if (!r_dig_end) begin
                            if (!digit) begin
                                n_dig_end = 1'b1;
                            end else begin
                                n_acc = (acc_next > (ACC_W+4)'(ppmp6_pkg::ACC_SAT)) ?
                                        ppmp6_pkg::ACC_SAT : acc_next[ACC_W-1:0];
                            end
                        end
                        n_tok_len = r_tok_len + LEN_W'(1);
                    end
                end
                ppmp6_pkg::PH_DATA: begin
                    if (i_item.end_of_input) begin
                        o_step.has_result       = 1'b1;
                        o_step.item.result_kind = ppmp6_pkg::KIND_ERROR;
                        o_step.item.error_code  = ppmp6_pkg::ERR_TRUNC;
                        do_rearm                = 1'b1;
                    end else if (r_two_byte && !r_byte_ph) begin
                        // hold the high byte until the low byte arrives
                        n_hi_hold = c;
                        n_byte_ph = 1'b1;
                    end else begin
                        n_byte_ph                = 1'b0;
                        o_step.has_result        = 1'b1;
                        o_step.item.result_kind  = ppmp6_pkg::KIND_PIXEL;
                        o_step.item.sample_value = r_two_byte ? {r_hi_hold, c} : {c, c};
                        o_step.item.component    = r_comp;
                        o_step.item.last_sample  = last;
                        if (r_comp == ppmp6_pkg::COMP_BLUE) begin
                            n_comp = ppmp6_pkg::COMP_RED;
                            if (r_col == r_width - DIM_BITS'(1)) begin
                                n_col = '0;
                                n_row = r_row + DIM_BITS'(1);
                            end else begin
                                n_col = r_col + DIM_BITS'(1);
                            end
                        end else begin
                            n_comp = r_comp + 2'd1;
                        end
                        if (last) begin
                            do_rearm    = 1'b1;
                            rearm_phase = ppmp6_pkg::PH_SKIP;
                        end
                    end
                end
                default: begin
                    // skip phase: drop bytes until end of input
                    if (i_item.end_of_input) begin
                        do_rearm = 1'b1;
                    end
                end
            endcase
        end

        if (do_rearm) begin
            n_phase   = rearm_phase;
            n_tok_num = ppmp6_pkg::TOK_MAGIC;
            n_in_cmt  = 1'b0;
            n_tok_len = '0;
            n_acc     = '0;
            n_dig_end = 1'b0;
            n_magic   = 1'b1;
            n_byte_ph = 1'b0;
            n_hi_hold = '0;
            n_comp    = ppmp6_pkg::COMP_RED;
            n_col     = '0;
            n_row     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ppmp6_pkg::PH_HEADER;
            r_tok_num  <= ppmp6_pkg::TOK_MAGIC;
            r_tok_len  <= '0;
            r_acc      <= '0;
            r_dig_end  <= 1'b0;
            r_magic    <= 1'b1;
            r_in_cmt   <= 1'b0;
            r_width    <= '0;
            r_height   <= '0;
            r_two_byte <= 1'b0;
            r_hi_hold  <= '0;
            r_byte_ph  <= 1'b0;
            r_comp     <= ppmp6_pkg::COMP_RED;
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            r_phase    <= n_phase;
            r_tok_num  <= n_tok_num;
            r_tok_len  <= n_tok_len;
            r_acc      <= n_acc;
            r_dig_end  <= n_dig_end;
            r_magic    <= n_magic;
            r_in_cmt   <= n_in_cmt;
            r_width    <= n_width;
            r_height   <= n_height;
            r_two_byte <= n_two_byte;
            r_hi_hold  <= n_hi_hold;
            r_byte_ph  <= n_byte_ph;
            r_comp     <= n_comp;
            r_col      <= n_col;
            r_row      <= n_row;
        end
    end

    a_hdr_leaves_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_step.has_result && o_step.item.result_kind == ppmp6_pkg::KIND_HEADER
        |=> r_phase != ppmp6_pkg::PH_HEADER)
        else $error("header result did not leave the header phase");

    a_err_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_step.has_result && o_step.item.result_kind == ppmp6_pkg::KIND_ERROR
        |-> o_step.item.error_code != ppmp6_pkg::ERR_NONE)
        else $error("error result without an error code");

    a_byte_phase_two_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_ph |-> r_two_byte && r_phase == ppmp6_pkg::PH_DATA)
        else $error("high byte held outside two-byte pixel data");

    a_token_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tok_len <= LEN_W'(MAX_TOKEN_LEN))
        else $error("token length passed its limit");

    a_last_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_step.has_result && o_step.item.result_kind == ppmp6_pkg::KIND_PIXEL &&
        o_step.item.last_sample |=> r_phase == ppmp6_pkg::PH_SKIP && r_comp == '0)
        else $error("last sample did not end the image");

endmodule

// ----- rtl/ppm_p6_stream_parser_unit.sv -----
// PPM P6 stream parser top level: byte input channel, result output register.
// Instantiates ppmp6_parse; depends on ppmp6_pkg.

// Takes a PPM P6 file one byte per transaction, then an end-of-input
// transaction, and gives a header result (width, height), then R,G,B 16-bit
// samples with the last one marked, or an error result. The block accepts one
// byte every cycle: each byte updates the parse state in the cycle it is
// accepted and any result appears in the output register in the next cycle.
// The input is ready whenever the output register is empty or being taken in
// the same cycle, so a stalled output stops input only while a result waits.
module ppm_p6_stream_parser_unit #(
    parameter int MAX_TOKEN_LEN = ppmp6_pkg::MAX_TOKEN_LEN_DEF,
    parameter int DIM_BITS      = ppmp6_pkg::DIM_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ppmp6_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ppmp6_pkg::t_out_item o_out_data
);

    logic                 fire;
    ppmp6_pkg::t_step     step;
    logic                 r_out_valid;
    ppmp6_pkg::t_out_item r_out_data;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign fire       = i_in_valid && o_in_ready;

    ppmp6_parse #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .DIM_BITS      (DIM_BITS)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (i_in_data),
        .o_step  (step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= step.has_result;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload: load on a new result, hold otherwise
    always_ff @(posedge i_clk) begin
        if (fire && step.has_result) begin
            r_out_data <= step.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_no_result_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !fire)
        else $error("byte accepted while a result waits");

    a_result_follows_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && step.has_result |=> r_out_valid)
        else $error("result of an accepted byte not registered");

    a_idle_step_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |-> !step.has_result)
        else $error("result produced without an accepted byte");

endmodule
